// ----- hw/rtl/c8_pkg.sv -----
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types and constants for the CHIP-8 core.
// ----------------------------------------------------------------------------
package c8_pkg;

    localparam int unsigned MEM_AW = 12;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_EXEC  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [15:0] keys_down;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } t_in_item;

    typedef struct packed {
        logic [15:0] program_counter;
        logic [63:0] row_pixels;
        logic        opcode_error;
        logic        waiting_for_key;
        logic        sound_on;
        logic        halted;
    } t_out_item;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] f [0:79];
        f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        return (a < 7'd80) ? f[a] : 8'h00;
    endfunction

endpackage

// ----- hw/rtl/c8_if.sv -----
// ----------------------------------------------------------------------------
// c8_in_if / c8_out_if
// Valid/ready channels for items in and out of the core.
// ----------------------------------------------------------------------------
interface c8_in_if;
    logic               valid;
    logic               ready;
    c8_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface c8_out_if;
    logic               valid;
    logic               ready;
    c8_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/c8_ram.sv -----
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module c8_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- hw/rtl/chip8_cpu_core.sv -----
// ----------------------------------------------------------------------------
// chip8_cpu_core
// CHIP-8 interpreter core: memory load, instruction execute, timer tick and
// framebuffer row read, one item at a time.
// ----------------------------------------------------------------------------
// After reset the core first runs a clearing pass over all 4096 main memory
// addresses (writing the font at 0x000 and 0x050, zeros elsewhere); the 32
// framebuffer rows are cleared at the start of that pass. No item is accepted
// meanwhile. Items are then handled one at a time through a sequencer around
// single-port memories; FX33, FX55, FX65, DXYN and 00E0 step through main
// memory or the framebuffer one address at a time. Each item ends in S_OUT,
// which offers the result, and no new item is accepted until that result has
// been taken.
module chip8_cpu_core #(
    parameter int unsigned STACK_SLOTS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_wdata,
    c8_in_if.sink        in_ch,
    c8_out_if.source     out_ch
);
    localparam int unsigned SW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int unsigned SLOT_WRAP = 65535 % STACK_SLOTS;

    typedef enum logic [16:0] {
        S_INIT   = 17'h00001,
        S_IDLE   = 17'h00002,
        S_FETCH1 = 17'h00004,
        S_FETCH2 = 17'h00008,
        S_FETCH3 = 17'h00010,
        S_EXEC   = 17'h00020,
        S_CLR    = 17'h00040,
        S_DRD    = 17'h00080,
        S_DFB    = 17'h00100,
        S_DWR    = 17'h00200,
        S_BCD    = 17'h00400,
        S_STO    = 17'h00800,
        S_LDR    = 17'h01000,
        S_LDW    = 17'h02000,
        S_RROW   = 17'h04000,
        S_RROW2  = 17'h08000,
        S_OUT    = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // memories
    logic        mem_we;
    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        fb_we;
    logic [4:0]  fb_addr;
    logic [63:0] fb_wdata, fb_rdata;

    c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata));
    c8_ram #(.WIDTH(64), .DEPTH(32)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_addr(fb_addr),
        .i_wdata(fb_wdata), .o_rdata(fb_rdata));

    logic [7:0]  r_v [0:15];
    logic [15:0] r_stk [0:STACK_SLOTS-1];
    logic [15:0] r_i, r_pc, r_sp;
    logic [SW-1:0] r_slot;
    logic [7:0]  r_dt, r_st;
    logic [12:0] r_cnt;
    logic [7:0]  r_hi, r_lo;
    c8_pkg::t_in_item  r_in;
    c8_pkg::t_out_item r_out;
    logic        r_ovalid;
    logic        r_err, r_wait, r_vf;
    logic [63:0] r_row;
    logic [7:0]  r_spr;

    logic [3:0]  x, y;
    logic [7:0]  vx, vy;
    logic [11:0] nnn;
    logic [15:0] pc2;
    logic [8:0]  add9;
    logic [SW-1:0] sp_slot, spm_slot, spp_slot;
    logic [15:0] spm;
    logic [4:0]  cy;
    logic [5:0]  cx;
    logic [63:0] spr_mask;
    logic [3:0]  h;
    logic [3:0]  hikey;
    logic [3:0]  d100, d10, d1;

    assign x   = r_hi[3:0];
    assign y   = r_lo[7:4];
    assign vx  = r_v[x];
    assign vy  = r_v[y];
    assign nnn = {r_hi[3:0], r_lo};
    assign pc2 = r_pc + 16'd2;
    assign add9 = {1'b0, vx} + {1'b0, vy};
    assign spm = r_sp - 16'd1;
    // r_slot tracks r_sp mod STACK_SLOTS, including the 16-bit wrap
    assign sp_slot  = r_slot;
    assign spm_slot = (r_sp == 16'd0) ? SW'(SLOT_WRAP)
                    : (r_slot == '0) ? SW'(STACK_SLOTS - 1) : r_slot - SW'(1);
    assign spp_slot = (r_sp == 16'hFFFF || r_slot == SW'(STACK_SLOTS - 1))
                    ? '0 : r_slot + SW'(1);
    assign cy  = vy[4:0];
    assign cx  = vx[5:0];
    assign h   = r_lo[3:0];
    assign spr_mask = ({r_spr, 56'd0}) >> cx;
    assign d100 = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;

    always_comb begin
        logic [7:0]  rem;
        logic [15:0] prod;
        rem = vx - 8'(d100) * 8'd100;
        // rem / 10 for rem < 100
        prod = {8'd0, rem} * 16'd205;
        d10 = prod[14:11];
        d1  = 4'(rem - 8'(d10) * 8'd10);
    end

    always_comb begin
        hikey = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_in.keys_down[k]) begin
                hikey = 4'(k);
            end
        end
    end

    assign in_ch.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid  = r_ovalid;
    assign out_ch.payload = r_out;

    // memory port control
    always_comb begin
        mem_we = 1'b0; mem_addr = r_pc[11:0]; mem_wdata = 8'd0;
        fb_we = 1'b0; fb_addr = r_cnt[4:0]; fb_wdata = 64'd0;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1; mem_addr = r_cnt[11:0];
                mem_wdata = (r_cnt[11:0] < 12'h050) ? c8_pkg::font_byte(r_cnt[6:0])
                          : (r_cnt[11:0] < 12'h0A0)
                            ? c8_pkg::font_byte(7'(r_cnt[11:0] - 12'h050)) : 8'd0;
                fb_we = !r_cnt[12] && (r_cnt[11:5] == 7'd0);
            end
            S_IDLE: begin
                mem_addr = in_ch.payload.load_address;
                mem_wdata = in_ch.payload.load_data;
                mem_we = in_ch.valid && !r_ovalid &&
                         (in_ch.payload.mode == c8_pkg::MODE_LOAD);
                fb_addr = in_ch.payload.row_select;
            end
            S_RROW, S_RROW2: fb_addr = r_in.row_select;
            S_FETCH1: mem_addr = r_pc[11:0];
            S_FETCH2: mem_addr = r_pc[11:0] + 12'd1;
            S_CLR: begin
                fb_we = 1'b1;
            end
            S_DRD: mem_addr = r_i[11:0] + 12'(r_cnt[3:0]);
            S_DFB: fb_addr = cy + 5'(r_cnt[3:0]);
            S_DWR: begin
                fb_addr = cy + 5'(r_cnt[3:0]);
                fb_we = 1'b1;
                fb_wdata = fb_rdata ^ spr_mask;
            end
            S_BCD: begin
                mem_we = 1'b1;
                mem_addr = r_i[11:0] + 12'(r_cnt[1:0]);
                mem_wdata = (r_cnt[1:0] == 2'd0) ? 8'(d100)
                          : (r_cnt[1:0] == 2'd1) ? 8'(d10) : 8'(d1);
            end
            S_STO: begin
                mem_we = 1'b1;
                mem_addr = r_i[11:0] + 12'(r_cnt[3:0]);
                mem_wdata = r_v[r_cnt[3:0]];
            end
            S_LDR, S_LDW: mem_addr = r_i[11:0] + 12'(r_cnt[3:0]);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_i  <= '0; r_pc <= 16'h0200; r_sp <= '0; r_slot <= '0;
            r_dt <= '0; r_st <= '0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < STACK_SLOTS; k++) r_stk[k] <= '0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (cfg_we) r_pc <= {4'd0, cfg_wdata};
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt == 13'd4095) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_in <= in_ch.payload;
                        r_err <= 1'b0; r_wait <= 1'b0; r_row <= '0;
                        unique case (c8_pkg::t_mode'(in_ch.payload.mode))
                            c8_pkg::MODE_LOAD: r_state <= S_OUT;
                            c8_pkg::MODE_EXEC:
                                r_state <= r_pc[15:12] != 4'd0 ? S_OUT : S_FETCH1;
                            c8_pkg::MODE_TICK: begin
                                if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                                if (r_st != 8'd0) r_st <= r_st - 8'd1;
                                r_state <= S_OUT;
                            end
                            c8_pkg::MODE_READ: r_state <= S_RROW;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_RROW: r_state <= S_RROW2;
                S_RROW2: begin
                    r_row <= fb_rdata;
                    r_state <= S_OUT;
                end
                S_FETCH1: r_state <= S_FETCH2;
                S_FETCH2: begin
                    r_hi <= mem_rdata;
                    r_state <= S_FETCH3;
                end
                S_FETCH3: begin
                    r_lo <= mem_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc <= pc2;
                    r_state <= S_OUT;
                    r_cnt <= '0;
                    case (r_hi[7:4])
                        4'h0: begin
                            if (r_lo == 8'hE0) r_state <= S_CLR;
                            else if (r_lo == 8'hEE) begin
                                r_sp <= spm;
                                r_slot <= spm_slot;
                                r_pc <= r_stk[spm_slot];
                            end else begin
                                r_err <= 1'b1;
                            end
                        end
                        4'h1: r_pc <= {4'd0, nnn};
                        4'h2: begin
                            r_stk[sp_slot] <= pc2;
                            r_sp <= r_sp + 16'd1;
                            r_slot <= spp_slot;
                            r_pc <= {4'd0, nnn};
                        end
                        4'h3: if (vx == r_lo) r_pc <= r_pc + 16'd4;
                        4'h4: if (vx != r_lo) r_pc <= r_pc + 16'd4;
                        4'h5: if (vx == vy) r_pc <= r_pc + 16'd4;
                        4'h6: r_v[x] <= r_lo;
                        4'h7: r_v[x] <= vx + r_lo;
                        4'h8: begin
                            case (r_lo[3:0])
                                4'h0: r_v[x] <= vy;
                                4'h1: begin r_v[x] <= vx | vy; r_v[15] <= 8'd0; end
                                4'h2: begin r_v[x] <= vx & vy; r_v[15] <= 8'd0; end
                                4'h3: begin r_v[x] <= vx ^ vy; r_v[15] <= 8'd0; end
                                4'h4: begin
                                    r_v[x] <= add9[7:0];
                                    r_v[15] <= {7'd0, add9[8]};
                                end
                                4'h5: begin
                                    r_v[x] <= vx - vy;
                                    r_v[15] <= {7'd0, vx >= vy};
                                end
                                4'h6: begin
                                    r_v[x] <= {1'b0, vy[7:1]};
                                    r_v[15] <= {7'd0, vy[0]};
                                end
                                4'h7: begin
                                    r_v[x] <= vy - vx;
                                    r_v[15] <= {7'd0, vy >= vx};
                                end
                                4'hE: begin
                                    r_v[x] <= {vy[6:0], 1'b0};
                                    r_v[15] <= {7'd0, vy[7]};
                                end
                                default: r_err <= 1'b1;
                            endcase
                        end
                        4'h9: if (vx != vy) r_pc <= r_pc + 16'd4;
                        4'hA: r_i <= {4'd0, nnn};
                        4'hB: r_pc <= {8'd0, r_v[0]} + {4'd0, nnn};
                        4'hC: r_v[x] <= r_in.random_byte & r_lo;
                        4'hD: begin
                            r_vf <= 1'b0;
                            if (h != 4'd0) r_state <= S_DRD;
                            else r_v[15] <= 8'd0;
                        end
                        4'hE: begin
                            if (r_lo == 8'h9E) begin
                                if (r_in.keys_down[vx[3:0]]) r_pc <= r_pc + 16'd4;
                            end else if (r_lo == 8'hA1) begin
                                if (!r_in.keys_down[vx[3:0]]) r_pc <= r_pc + 16'd4;
                            end else begin
                                r_err <= 1'b1;
                            end
                        end
                        default: begin
                            case (r_lo)
                                8'h07: r_v[x] <= r_dt;
                                8'h0A: begin
                                    if (r_in.keys_down == 16'd0) begin
                                        r_pc <= r_pc; r_wait <= 1'b1;
                                    end else r_v[x] <= {4'd0, hikey};
                                end
                                8'h15: r_dt <= vx;
                                8'h18: r_st <= vx;
                                8'h1E: r_i <= r_i + {8'd0, vx};
                                8'h29: r_i <= {10'd0, vx[3:0], 2'd0} + {12'd0, vx[3:0]};
                                8'h33: r_state <= S_BCD;
                                8'h55: r_state <= S_STO;
                                8'h65: r_state <= S_LDR;
                                default: r_err <= 1'b1;
                            endcase
                        end
                    endcase
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt[4:0] == 5'd31) r_state <= S_OUT;
                end
                S_DRD: begin
                    if ({1'b0, cy} + {2'b0, r_cnt[3:0]} > 6'd31) begin
                        r_v[15] <= {7'd0, r_vf};
                        r_state <= S_OUT;
                    end else r_state <= S_DFB;
                end
                S_DFB: begin
                    r_spr <= mem_rdata;
                    r_state <= S_DWR;
                end
                S_DWR: begin
                    if ((fb_rdata & spr_mask) != 64'd0) r_vf <= 1'b1;
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt[3:0] + 4'd1 == h) begin
                        r_v[15] <= {7'd0, r_vf || ((fb_rdata & spr_mask) != 64'd0)};
                        r_state <= S_OUT;
                    end else r_state <= S_DRD;
                end
                S_BCD: begin
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt[1:0] == 2'd2) r_state <= S_OUT;
                end
                S_STO: begin
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt[3:0] == x) begin
                        r_i <= r_i + 16'd1;
                        r_state <= S_OUT;
                    end
                end
                S_LDR: r_state <= S_LDW;
                S_LDW: begin
                    r_v[r_cnt[3:0]] <= mem_rdata;
                    r_cnt <= r_cnt + 13'd1;
                    if (r_cnt[3:0] == x) begin
                        r_i <= r_i + 16'd1;
                        r_state <= S_OUT;
                    end else r_state <= S_LDR;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && n_state == S_OUT) begin
            r_out.program_counter <= r_pc;
            r_out.row_pixels      <= r_row;
            r_out.opcode_error    <= r_err;
            r_out.waiting_for_key <= r_wait;
            r_out.sound_on        <= r_st != 8'd0;
            r_out.halted          <= r_pc[15:12] != 4'd0;
        end
    end
endmodule
